// ===== rtl/vfc_pkg.sv =====
// Shared types and constants for the versioned frame checker.
package vfc_pkg;

   localparam int MaxMagicBytes = 8;
   localparam int MagicIdxW     = $clog2(MaxMagicBytes) > 0 ? $clog2(MaxMagicBytes) : 1;
   localparam int CountW        = 33;

   localparam logic [31:0] CrcPoly = 32'h82F6_3B78;

   // register indexes
   localparam logic [1:0] CSR_MAGIC_VALUE = 2'd0;
   localparam logic [1:0] CSR_MAGIC_LEN   = 2'd1;
   localparam logic [1:0] CSR_VERSION     = 2'd2;
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd3;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_MAGIC     = 3'd2;
   localparam logic [2:0] ST_VERSION   = 3'd3;
   localparam logic [2:0] ST_TOO_LARGE = 3'd4;
   localparam logic [2:0] ST_LENGTH    = 3'd5;
   localparam logic [2:0] ST_CHECKSUM  = 3'd6;

   typedef struct packed {
      logic [63:0] magic_value;
      logic [3:0]  magic_len;     // effective length, 1..MaxMagicBytes
      logic [31:0] version;
      logic [31:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] payload_byte;
      logic [2:0] status;
   } result_type;

endpackage

// ===== rtl/versioned_frame_checker.sv =====
// Top level: configuration registers, input word register, frame checker core, result word register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data_byte, req_end_of_frame
//   rsp      out        rsp_valid / rsp_stall  rsp_kind, rsp_payload_byte, rsp_status
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// One word per cycle sustained unless a held result stalls the core. A taken word passes
// the input register, then the result register, before it is on rsp.
// Synchronous reset clears the handshake state and the frame state and sets the
// configuration registers to their defaults.
// A held result stalls the core only when the word in the input register makes a
// result of its own; words that make none drain past a stalled rsp.
module versioned_frame_checker import vfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic       s_valid_ff, s_valid_in;
   logic [7:0] s_byte_ff;
   logic       s_eof_ff;
   logic       o_valid_ff, o_valid_in;
   logic       o_kind_ff;
   logic [7:0] o_byte_ff;
   logic [2:0] o_status_ff;
   logic       advance, take, out_free;

   vfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vfc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .advance      (advance),
      .data_byte    (s_byte_ff),
      .end_of_frame (s_eof_ff),
      .result       (result)
   );

   assign out_free  = !o_valid_ff || !rsp_stall;
   assign advance   = s_valid_ff && (!result.valid || out_free);
   assign req_stall = s_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      s_valid_in = take | (s_valid_ff & ~advance);
      o_valid_in = (advance && result.valid) || (o_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s_byte_ff <= req_data_byte;
         s_eof_ff  <= req_end_of_frame;
      end
      if (advance && result.valid) begin
         o_kind_ff   <= result.kind;
         o_byte_ff   <= result.payload_byte;
         o_status_ff <= result.status;
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_kind         = o_kind_ff;
   assign rsp_payload_byte = o_byte_ff;
   assign rsp_status       = o_status_ff;

endmodule

// ===== rtl/vfc_csr.sv =====
// Configuration registers and effective magic length.
module vfc_csr import vfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output cfg_type     cfg
);

   logic [63:0] magic_value_ff, magic_value_in;
   logic [3:0]  magic_len_ff, magic_len_in;
   logic [31:0] version_ff, version_in;
   logic [31:0] max_payload_ff, max_payload_in;

   always_comb begin
      magic_value_in = magic_value_ff;
      magic_len_in   = magic_len_ff;
      version_in     = version_ff;
      max_payload_in = max_payload_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAGIC_VALUE: magic_value_in = csr_wdata;
            CSR_MAGIC_LEN:   magic_len_in   = csr_wdata[3:0];
            CSR_VERSION:     version_in     = csr_wdata[31:0];
            CSR_MAX_PAYLOAD: max_payload_in = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_value_ff <= '0;
         magic_len_ff   <= 4'd4;
         version_ff     <= 32'd1;
         max_payload_ff <= 32'd65536;
      end else begin
         magic_value_ff <= magic_value_in;
         magic_len_ff   <= magic_len_in;
         version_ff     <= version_in;
         max_payload_ff <= max_payload_in;
      end
   end

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      cfg.magic_value = magic_value_ff;
      cfg.version     = version_ff;
      cfg.max_payload = max_payload_ff;
      if (magic_len_ff == 4'd0)
         cfg.magic_len = 4'd1;
      else if (magic_len_ff > 4'(MaxMagicBytes))
         cfg.magic_len = 4'(MaxMagicBytes);
      else
         cfg.magic_len = magic_len_ff;
   end

endmodule

// ===== rtl/vfc_core.sv =====
// Frame parser state, CRC-32C update and end-of-frame status.
module vfc_core import vfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       advance,
   input  logic [7:0] data_byte,
   input  logic       end_of_frame,
   output result_type result
);

   logic [CountW-1:0] count_ff, count_in;
   logic              magic_bad_ff, magic_bad_in;
   logic [31:0]       version_ff, version_in;
   logic [31:0]       length_ff, length_in;
   logic [31:0]       crc_ff, crc_in;
   logic [31:0]       crc_rx_ff, crc_rx_in;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++)
         c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
      return c;
   endfunction

   // positions widened so that sums never wrap
   logic [CountW:0]    pos, total, ml, ver_end, pstart, pend, crc_end;
   logic [MagicIdxW-1:0] mag_idx;
   logic [7:0]         want;
   logic               in_magic, in_version, in_length, in_payload, in_crc;
   logic [2:0]         status;

   always_comb begin
      pos     = {1'b0, count_ff};
      total   = pos + 1'b1;
      ml      = (CountW+1)'(cfg.magic_len);
      ver_end = ml + (CountW+1)'(4);
      pstart  = ml + (CountW+1)'(8);
      pend    = pstart + (CountW+1)'(length_ff);
      crc_end = pend + (CountW+1)'(4);

      in_magic   = pos < ml;
      in_version = !in_magic && pos < ver_end;
      in_length  = !in_magic && !in_version && pos < pstart;
      in_payload = pos >= pstart && pos < pend;
      in_crc     = pos >= pstart && !in_payload && pos < crc_end;

      mag_idx = MagicIdxW'(cfg.magic_len - 4'd1 - {1'b0, count_ff[MagicIdxW-1:0]});
      want    = cfg.magic_value[{mag_idx, 3'b000} +: 8];

      magic_bad_in = magic_bad_ff | (in_magic && want != data_byte);
      version_in   = in_version ? {version_ff[23:0], data_byte} : version_ff;
      length_in    = in_length ? {length_ff[23:0], data_byte} : length_ff;
      crc_in       = in_payload ? crc_byte(crc_ff, data_byte) : crc_ff;
      crc_rx_in    = in_crc ? {crc_rx_ff[23:0], data_byte} : crc_rx_ff;
      count_in     = (&count_ff) ? count_ff : count_ff + 1'b1;

      // the final byte's own contribution counts toward the checks
      if (total < pstart + (CountW+1)'(4))
         status = ST_TRUNCATED;
      else if (magic_bad_in)
         status = ST_MAGIC;
      else if (version_in != cfg.version)
         status = ST_VERSION;
      else if (length_in > cfg.max_payload)
         status = ST_TOO_LARGE;
      else if (total != crc_end)
         status = ST_LENGTH;
      else if (~crc_in != crc_rx_in)
         status = ST_CHECKSUM;
      else
         status = ST_OK;

      result.valid        = end_of_frame || in_payload;
      result.kind         = end_of_frame ? KIND_STATUS : KIND_PAYLOAD;
      result.payload_byte = end_of_frame ? 8'd0 : data_byte;
      result.status       = end_of_frame ? status : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && end_of_frame)) begin
         count_ff     <= '0;
         magic_bad_ff <= 1'b0;
         version_ff   <= '0;
         length_ff    <= '0;
         crc_ff       <= '1;
         crc_rx_ff    <= '0;
      end else if (advance) begin
         count_ff     <= count_in;
         magic_bad_ff <= magic_bad_in;
         version_ff   <= version_in;
         length_ff    <= length_in;
         crc_ff       <= crc_in;
         crc_rx_ff    <= crc_rx_in;
      end
   end

endmodule

// ===== bench/versioned_frame_checker_tb.sv =====
// Self-checking testbench for the versioned frame checker: framed byte traffic vs. a predictor.
`timescale 1ns / 100ps

module versioned_frame_checker_tb;
   import vfc_pkg::*;

   localparam int QUIET_LIMIT = 3000;

   typedef logic [7:0] octet_q_type[$];

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [2:0] status;
   } result_word_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_MAGIC,
      FRAME_BAD_VERSION,
      FRAME_TOO_LARGE,
      FRAME_LEN_OVER,
      FRAME_LEN_UNDER,
      FRAME_BAD_CRC,
      FRAME_TRAILING,
      FRAME_CUT_HEADER,
      FRAME_CUT_PAYLOAD
   } frame_shape_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte    = 8'h00;
   logic        req_end_of_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_status;
   logic        csr_wr_en        = 1'b0;
   logic [1:0]  csr_index        = CSR_MAGIC_VALUE;
   logic [63:0] csr_wdata        = 64'h0;

   // register copies, as the block should hold them
   logic [63:0] cfg_magic_value = 64'h0;
   logic [3:0]  cfg_magic_len   = 4'd4;
   logic [31:0] cfg_version     = 32'd1;
   logic [31:0] cfg_max_payload = 32'd65536;

   // frame state of the predictor
   logic [32:0] frame_count;
   logic        magic_mismatch;
   logic [31:0] version_acc;
   logic [31:0] length_acc;
   logic [31:0] crc_acc;
   logic [31:0] crc_seen;

   result_word_type due_words[$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int words_sent = 0;
   int frames_sent = 0;
   int payload_seen = 0;
   int status_seen[0:6];

   versioned_frame_checker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   //------------------------------------------------------------------
   // predictor
   //------------------------------------------------------------------
   function automatic logic [31:0] crc32c_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      int k;
      c = crc ^ {24'h0, b};
      for (k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      return c;
   endfunction

   function automatic int magic_len_eff();
      if (cfg_magic_len == 4'd0)
         return 1;
      if (cfg_magic_len > MaxMagicBytes)
         return MaxMagicBytes;
      return int'(cfg_magic_len);
   endfunction

   function automatic void clear_frame_state();
      frame_count    = '0;
      magic_mismatch = 1'b0;
      version_acc    = '0;
      length_acc     = '0;
      crc_acc        = '1;
      crc_seen       = '0;
   endfunction

   // advance the frame state by one byte; returns 1 when a result word is due
   function automatic bit frame_check_step(input logic [7:0] b, input logic eof,
                                           output result_word_type r);
      longint unsigned ml, pstart, pos, pend, total;
      logic [7:0]  want;
      logic [31:0] crc_final;
      bit          is_payload;
      ml         = longint'(magic_len_eff());
      pstart     = ml + 8;
      pos        = frame_count;
      is_payload = 1'b0;
      r          = '{KIND_PAYLOAD, 8'h00, ST_OK};
      if (pos < ml) begin
         want = 8'(cfg_magic_value >> (8 * (ml - 1 - pos)));
         if (want != b)
            magic_mismatch = 1'b1;
      end else if (pos < ml + 4) begin
         version_acc = {version_acc[23:0], b};
      end else if (pos < pstart) begin
         length_acc = {length_acc[23:0], b};
      end else begin
         pend = pstart + length_acc;
         if (pos < pend) begin
            crc_acc    = crc32c_update(crc_acc, b);
            is_payload = 1'b1;
         end else if (pos < pend + 4) begin
            crc_seen = {crc_seen[23:0], b};
         end
      end
      if (frame_count != {33{1'b1}})
         frame_count = frame_count + 33'd1;

      if (!eof) begin
         r.payload_byte = b;
         return is_payload;
      end

      // final byte: a payload byte here is swallowed, only the status goes out
      total     = pos + 1;
      crc_final = ~crc_acc;
      r.kind    = KIND_STATUS;
      if (total < pstart + 4)
         r.status = ST_TRUNCATED;
      else if (magic_mismatch)
         r.status = ST_MAGIC;
      else if (version_acc != cfg_version)
         r.status = ST_VERSION;
      else if (length_acc > cfg_max_payload)
         r.status = ST_TOO_LARGE;
      else if (total != pstart + length_acc + 4)
         r.status = ST_LENGTH;
      else if (crc_final != crc_seen)
         r.status = ST_CHECKSUM;
      else
         r.status = ST_OK;
      clear_frame_state();
      return 1'b1;
   endfunction

   //------------------------------------------------------------------
   // drivers
   //------------------------------------------------------------------
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MAGIC_VALUE: cfg_magic_value = value;
         CSR_MAGIC_LEN:   cfg_magic_len   = value[3:0];
         CSR_VERSION:     cfg_version     = value[31:0];
         CSR_MAX_PAYLOAD: cfg_max_payload = value[31:0];
         default: ;
      endcase
   endtask

   task automatic send_word(input logic [7:0] b, input logic eof);
      int gap;
      result_word_type r;
      if ($urandom_range(99) < tx_idle_pct) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_frame <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (frame_check_step(b, eof, r))
         due_words = {due_words, r};
      words_sent++;
   endtask

   task automatic send_bytes(input octet_q_type bytes);
      foreach (bytes[i])
         send_word(bytes[i], i == bytes.size() - 1);
      frames_sent++;
   endtask

   // lower valid, let every due word come out, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic build_frame(input frame_shape_type shape, input int plen_in,
                              output octet_q_type bytes);
      int          n, plen, bad_at, cut, i;
      logic [7:0]  b;
      logic [31:0] len_word, ver_word, crc;
      bytes = {};
      n     = magic_len_eff();
      plen  = plen_in;
      if (shape != FRAME_TOO_LARGE && plen > cfg_max_payload)
         plen = int'(cfg_max_payload);
      if ((shape == FRAME_CUT_PAYLOAD || shape == FRAME_LEN_UNDER) && plen == 0)
         plen = 1;
      len_word = plen;
      case (shape)
         FRAME_TOO_LARGE:
            len_word = (cfg_max_payload > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF :
                       cfg_max_payload + 32'd1 + $urandom_range(0, 3);
         FRAME_LEN_OVER:  len_word = plen + $urandom_range(1, 3);
         FRAME_LEN_UNDER: len_word = plen - $urandom_range(1, plen);
         default: ;
      endcase
      ver_word = cfg_version;
      if (shape == FRAME_BAD_VERSION)
         ver_word = ver_word ^ ($urandom | (32'h1 << $urandom_range(0, 31)));
      bad_at = (shape == FRAME_BAD_MAGIC) ? int'($urandom_range(0, n - 1)) : -1;

      for (i = 0; i < n; i++) begin
         b = 8'(cfg_magic_value >> (8 * (n - 1 - i)));
         if (i == bad_at)
            b = b ^ 8'($urandom_range(1, 255));
         bytes = {bytes, b};
      end
      for (i = 3; i >= 0; i--)
         bytes = {bytes, ver_word[8*i +: 8]};
      for (i = 3; i >= 0; i--)
         bytes = {bytes, len_word[8*i +: 8]};
      crc = '1;
      for (i = 0; i < plen; i++) begin
         b = 8'($urandom);
         bytes = {bytes, b};
         crc = crc32c_update(crc, b);
      end
      crc = ~crc;
      if (shape == FRAME_BAD_CRC)
         crc = crc ^ (32'h1 << $urandom_range(0, 31));
      for (i = 3; i >= 0; i--)
         bytes = {bytes, crc[8*i +: 8]};
      if (shape == FRAME_TRAILING)
         repeat ($urandom_range(1, 5)) bytes = {bytes, 8'($urandom)};

      cut = bytes.size();
      if (shape == FRAME_CUT_HEADER)
         cut = $urandom_range(1, n + 11);
      else if (shape == FRAME_CUT_PAYLOAD)
         cut = n + 8 + $urandom_range(1, plen);   // last byte lands in the payload
      while (bytes.size() > cut)
         void'(bytes.pop_back());
   endtask

   task automatic send_shaped(input frame_shape_type shape, input int plen);
      octet_q_type bytes;
      build_frame(shape, plen, bytes);
      send_bytes(bytes);
   endtask

   task automatic send_noise(input int count);
      octet_q_type bytes;
      bytes = {};
      repeat (count) bytes = {bytes, 8'($urandom)};
      send_bytes(bytes);
   endtask

   task automatic randomize_config();
      logic [63:0] value;
      case ($urandom_range(3))
         0:       value = '0;
         1:       value = '1;
         default: value = {$urandom, $urandom};
      endcase
      write_csr(CSR_MAGIC_VALUE, value);

      value = {$urandom, $urandom};
      value[3:0] = ($urandom_range(9) < 7) ? 4'($urandom_range(1, 8)) :
                                             4'($urandom_range(0, 15));
      write_csr(CSR_MAGIC_LEN, value);

      value = {$urandom, $urandom};
      case ($urandom_range(5))
         0:       value[31:0] = '0;
         1:       value[31:0] = '1;
         default: ;
      endcase
      write_csr(CSR_VERSION, value);

      value = {$urandom, $urandom};
      case ($urandom_range(5))
         0:       value[31:0] = '0;
         1:       value[31:0] = '1;
         2, 3:    value[31:0] = $urandom_range(0, 64);
         default: value[31:0] = $urandom_range(65, 100000);
      endcase
      write_csr(CSR_MAX_PAYLOAD, value);
   endtask

   task automatic send_random_frame();
      int pick, plen;
      pick = $urandom_range(99);
      plen = ($urandom_range(99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 120);
      if (pick < 65)
         send_shaped(FRAME_GOOD, plen);
      else if (pick < 92)
         send_shaped(frame_shape_type'($urandom_range(1, int'(FRAME_CUT_PAYLOAD))), plen);
      else
         send_noise($urandom_range(1, 20));
   endtask

   //------------------------------------------------------------------
   // tests
   //------------------------------------------------------------------
   task automatic test_reset_defaults();
      send_shaped(FRAME_GOOD, 3);
      send_noise(1);
      drain();
   endtask

   task automatic test_status_codes();
      int k;
      write_csr(CSR_MAGIC_LEN, 64'd2);
      write_csr(CSR_MAGIC_VALUE, 64'h5AC3);
      for (k = 0; k <= int'(FRAME_CUT_PAYLOAD); k++)
         send_shaped(frame_shape_type'(k), 2);
      drain();
   endtask

   // zero must act as one, anything above the maximum as the maximum
   task automatic test_magic_length_limits();
      logic [3:0] len_list [0:4];
      int k;
      len_list = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd9};
      for (k = 0; k < 5; k++) begin
         write_csr(CSR_MAGIC_VALUE, {$urandom, $urandom});
         write_csr(CSR_MAGIC_LEN, 64'(len_list[k]));
         send_shaped(FRAME_GOOD, 1);
         send_shaped(FRAME_BAD_MAGIC, 0);
         drain();
      end
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_MAGIC_LEN, 64'd3);
      write_csr(CSR_MAGIC_VALUE, 64'h0);
      send_shaped(FRAME_GOOD, 2);
      drain();
      write_csr(CSR_MAGIC_VALUE, '1);
      send_shaped(FRAME_GOOD, 2);
      send_shaped(FRAME_BAD_MAGIC, 1);
      drain();
      write_csr(CSR_VERSION, 64'h0);
      send_shaped(FRAME_GOOD, 1);
      send_shaped(FRAME_BAD_VERSION, 1);
      drain();
      write_csr(CSR_VERSION, 64'hFFFF_FFFF);
      send_shaped(FRAME_GOOD, 1);
      send_shaped(FRAME_BAD_VERSION, 1);
      drain();
      write_csr(CSR_MAX_PAYLOAD, 64'h0);
      send_shaped(FRAME_GOOD, 4);
      send_shaped(FRAME_TOO_LARGE, 1);
      drain();
      write_csr(CSR_MAX_PAYLOAD, 64'hFFFF_FFFF);
      send_shaped(FRAME_GOOD, 6);
      send_shaped(FRAME_TOO_LARGE, 2);
      drain();
   endtask

   // long receiver hold while the sender keeps pushing payload
   task automatic test_backpressure();
      int saved_tx;
      saved_tx = tx_idle_pct;
      write_csr(CSR_MAX_PAYLOAD, 64'd4096);
      tx_idle_pct  = 0;
      rx_hold_left = 400;
      send_shaped(FRAME_GOOD, 160);
      drain();
      tx_idle_pct = saved_tx;
   endtask

   task automatic test_random_traffic();
      int phase, phase_goal;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin tx_idle_pct = 33; rx_idle_pct = 78; end
            1:       begin tx_idle_pct = 78; rx_idle_pct = 33; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
         endcase
         phase_goal = words_sent + 280;
         randomize_config();
         while (words_sent < phase_goal) begin
            send_random_frame();
            if ($urandom_range(11) == 0) begin
               drain();
               randomize_config();
            end
         end
         drain();
      end
   endtask

   //------------------------------------------------------------------
   // receiver, checker, watchdog
   //------------------------------------------------------------------
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 30)
         $display("%0t: mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind=%0b byte=%02h status=%0d",
                                      rsp_kind, rsp_payload_byte, rsp_status));
         end else begin
            want = due_words.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0b, want %0b", rsp_kind, want.kind));
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch($sformatf("payload byte %02h, want %02h",
                                         rsp_payload_byte, want.payload_byte));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (want.kind == KIND_STATUS)
               status_seen[want.status]++;
            else
               payload_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words still due",
                     QUIET_LIMIT, due_words.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   //------------------------------------------------------------------
   // sequence
   //------------------------------------------------------------------
   initial begin
      foreach (status_seen[s])
         status_seen[s] = 0;
      clear_frame_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 33;
      rx_idle_pct = 78;
      test_reset_defaults();
      test_status_codes();
      test_magic_length_limits();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      drain();

      $display("Sent %0d bytes in %0d frames across random register settings and idle mixes.",
               words_sent, frames_sent);
      $display({"Checked %0d payload words; statuses ok/trunc/magic/ver/large/len/crc: ",
                "%0d/%0d/%0d/%0d/%0d/%0d/%0d"},
               payload_seen, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3], status_seen[4], status_seen[5], status_seen[6]);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
